// ----- rtl/rtpts_pkg.sv -----
// Shared types and constants for the RTP / transport stream datagram checker.
package rtpts_pkg;

   localparam logic [1:0] VERDICT_DROP     = 2'd0;
   localparam logic [1:0] VERDICT_RAW      = 2'd1;
   localparam logic [1:0] VERDICT_RTP      = 2'd2;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd3;

   localparam logic [7:0]  TS_SYNC      = 8'h47;
   localparam logic [7:0]  TS_LAST_MOD  = 8'd187;
   localparam logic [1:0]  RTP_VERSION  = 2'd2;
   localparam logic [17:0] HDR_SAT      = 18'h3FFFF;
   localparam logic [15:0] POS_MAX      = 16'hFFFF;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
      logic        track_sequence;
      logic [15:0] sequence_word;
   } entry_type;

endpackage

// ----- rtl/rtpts_front.sv -----
// Front end: takes datagram beats, parses the header and classifies each datagram.
module rtpts_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [31:0]          csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  logic [31:0]          req_dest_address,
   output logic                 push_valid,
   input  logic                 push_ready,
   output rtpts_pkg::entry_type push_data
);

   logic [31:0] stream_address_ff;
   logic [15:0] pos_ff, pos_in;
   logic        oversize_ff, oversize_in;
   logic [7:0]  fhb_ff, fhb_in;
   logic [17:0] hlen_ff, hlen_in;
   logic [7:0]  ehb_ff, ehb_in;
   logic [7:0]  mod_ff, mod_in;
   logic        sync_ff, sync_in;
   logic [15:0] seq_ff, seq_in;

   logic        accept;
   logic        take;
   logic [15:0] h0;
   logic        xbit;
   logic        ext_hi_hit;
   logic        ext_lo_hit;
   logic [18:0] hlen_ext;
   logic        final_part;
   logic        in_payload;
   logic [16:0] len;
   logic        mismatch;
   logic        is_raw;
   logic        longer;
   logic        payload_ok;

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && req_last_byte;

   always_comb begin
      take = !oversize_ff;
      h0   = 16'd12 + {10'd0, fhb_ff[3:0], 2'b00};
      xbit = fhb_ff[4];

      fhb_in  = fhb_ff;
      hlen_in = hlen_ff;
      ehb_in  = ehb_ff;
      seq_in  = seq_ff;
      sync_in = sync_ff;
      mod_in  = mod_ff;

      if (take && pos_ff == 16'd0) begin
         fhb_in  = req_data_byte;
         hlen_in = 18'd12 + {12'd0, req_data_byte[3:0], 2'b00};
      end
      if (take && pos_ff == 16'd2) begin
         seq_in = {req_data_byte, seq_ff[7:0]};
      end
      if (take && pos_ff == 16'd3) begin
         seq_in = {seq_ff[15:8], req_data_byte};
      end

      ext_hi_hit = take && xbit && (pos_ff == h0 + 16'd2);
      ext_lo_hit = take && xbit && (pos_ff == h0 + 16'd3);
      hlen_ext   = {1'b0, ehb_ff, req_data_byte, 2'b00} + 19'd4 + {3'd0, h0};
      if (ext_hi_hit) begin
         ehb_in = req_data_byte;
      end
      if (ext_lo_hit) begin
         hlen_in = (hlen_ext > {1'b0, rtpts_pkg::HDR_SAT}) ? rtpts_pkg::HDR_SAT
                                                            : hlen_ext[17:0];
      end

      final_part = !xbit || (pos_ff >= h0 + 16'd4);
      in_payload = take && (pos_ff != 16'd0) && final_part && ({2'b00, pos_ff} >= hlen_ff);
      if (in_payload) begin
         if ({2'b00, pos_ff} == hlen_ff) begin
            sync_in = (req_data_byte == rtpts_pkg::TS_SYNC);
         end
         mod_in = (mod_ff == rtpts_pkg::TS_LAST_MOD) ? 8'd0 : mod_ff + 8'd1;
      end

      oversize_in = oversize_ff || (pos_ff == rtpts_pkg::POS_MAX);
      pos_in      = (!oversize_ff && pos_ff != rtpts_pkg::POS_MAX) ? pos_ff + 16'd1 : pos_ff;
      len         = oversize_in ? 17'h10000 : {1'b0, pos_in};

      mismatch   = (stream_address_ff != 32'd0) && (req_dest_address != stream_address_ff);
      is_raw     = (fhb_in == rtpts_pkg::TS_SYNC);
      longer     = (len > 17'd3);
      payload_ok = !oversize_in && (fhb_in[7:6] == rtpts_pkg::RTP_VERSION)
                   && (hlen_in < {1'b0, len}) && sync_in && (mod_in == 8'd0);

      push_data                = '0;
      push_data.sequence_word  = seq_in;
      if (mismatch) begin
         push_data.verdict = rtpts_pkg::VERDICT_MISMATCH;
      end else if (is_raw) begin
         if (!oversize_in) begin
            push_data.verdict        = rtpts_pkg::VERDICT_RAW;
            push_data.payload_length = len[15:0];
         end
      end else if (longer) begin
         push_data.track_sequence = 1'b1;
         if (payload_ok) begin
            push_data.verdict        = rtpts_pkg::VERDICT_RTP;
            push_data.payload_offset = hlen_in[15:0];
            push_data.payload_length = len[15:0] - hlen_in[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_address_ff <= '0;
      end else if (csr_write_enable) begin
         stream_address_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         pos_ff      <= '0;
         oversize_ff <= 1'b0;
         fhb_ff      <= '0;
         hlen_ff     <= '0;
         ehb_ff      <= '0;
         mod_ff      <= '0;
         sync_ff     <= 1'b0;
         seq_ff      <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         oversize_ff <= oversize_in;
         fhb_ff      <= fhb_in;
         hlen_ff     <= hlen_in;
         ehb_ff      <= ehb_in;
         mod_ff      <= mod_in;
         sync_ff     <= sync_in;
         seq_ff      <= seq_in;
      end
   end

endmodule

// ----- rtl/rtpts_queue.sv -----
// Short FIFO of classified datagrams between the front and back ends.
module rtpts_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  rtpts_pkg::entry_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rtpts_pkg::entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rtpts_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/rtpts_back.sv -----
// Back end: tracks RTP sequence continuity, counts gaps and holds the result beat.
module rtpts_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  rtpts_pkg::entry_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_verdict,
   output logic [15:0]          rsp_payload_offset,
   output logic [15:0]          rsp_payload_length,
   output logic                 rsp_sequence_gap,
   output logic [31:0]          rsp_gap_count
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] prev_seq_ff;
   logic        seq_valid_ff;
   logic [31:0] gap_counter_ff, gap_counter_in;
   logic [1:0]  verdict_ff;
   logic [15:0] offset_ff;
   logic [15:0] length_ff;
   logic        gap_ff;
   logic [31:0] count_out_ff;

   logic        pop;
   logic        gap;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      gap = pop_data.track_sequence && seq_valid_ff
            && (pop_data.sequence_word != prev_seq_ff + 16'd1);
      gap_counter_in = (gap && gap_counter_ff != rtpts_pkg::COUNT_MAX)
                       ? gap_counter_ff + 32'd1 : gap_counter_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         prev_seq_ff    <= '0;
         seq_valid_ff   <= 1'b0;
         gap_counter_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            gap_counter_ff <= gap_counter_in;
            if (pop_data.track_sequence) begin
               prev_seq_ff  <= pop_data.sequence_word;
               seq_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         verdict_ff   <= pop_data.verdict;
         offset_ff    <= pop_data.payload_offset;
         length_ff    <= pop_data.payload_length;
         gap_ff       <= gap;
         count_out_ff <= gap_counter_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_payload_offset = offset_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_sequence_gap   = gap_ff;
   assign rsp_gap_count      = count_out_ff;

endmodule

// ----- rtl/rtp_ts_payload_checker_unit.sv -----
// Top level of the RTP / MPEG-2 transport stream datagram checker.
// Datagram bytes enter one beat per clock on the req_ channel; each beat marked
// last yields one result beat on the rsp_ channel once its entry has passed the
// queue and the back-end output register. The front end parses the header as the
// bytes stream by and pushes one classified entry per datagram into a queue of
// QUEUE_DEPTH entries; the back end tracks sequence continuity and holds the
// result in an output register, so bytes keep flowing while a result waits.
// Input stalls only when the queue is full. Write csr_write_data with
// csr_write_enable to set the stream address; zero accepts any destination.
module rtp_ts_payload_checker_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_dest_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [15:0] rsp_payload_offset,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_sequence_gap,
   output logic [31:0] rsp_gap_count
);

   logic                 push_valid;
   logic                 push_ready;
   rtpts_pkg::entry_type push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   rtpts_pkg::entry_type pop_data;

   rtpts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_dest_address (req_dest_address),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   rtpts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rtpts_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_sequence_gap   (rsp_sequence_gap),
      .rsp_gap_count      (rsp_gap_count)
   );

endmodule
